@@ design/pnprts_pkg.sv @@
// ----------------------------------------------------------------------------
// pnprts_pkg: shared definitions for the PnP resource tag scanner
// Register map, search mode codes, tag constants and the configuration bundle.
// ----------------------------------------------------------------------------
package pnprts_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int RESULT_OFF_W    = 16;
  localparam int APB_ADDR_W      = 4;
  localparam int APB_DATA_W      = 32;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_SEARCH_MODE = 2'd0,
    REG_WANTED_TAG  = 2'd1,
    REG_WANTED_TYPE = 2'd2,
    REG_OCCURRENCE  = 2'd3
  } reg_idx_t;

  localparam logic [1:0] MODE_GENERIC      = 2'd0;
  localparam logic [1:0] MODE_SMALL_VENDOR = 2'd1;
  localparam logic [1:0] MODE_LARGE_VENDOR = 2'd2;

  localparam logic [7:0] END_TAG       = 8'h78;
  localparam logic [7:0] SMALL_VENDOR  = 8'h70;
  localparam logic [7:0] LARGE_VENDOR  = 8'h84;
  localparam logic [7:0] TAG_MASK      = 8'hF8;
  localparam logic [7:0] FULL_MASK     = 8'hFF;

  // Distance from a vendor header to its type byte.
  localparam logic [1:0] SMALL_TYPE_DIST = 2'd1;
  localparam logic [1:0] LARGE_TYPE_DIST = 2'd3;

  typedef struct packed {
    logic [1:0] search_mode;
    logic [7:0] wanted_tag;
    logic [7:0] wanted_type;
    logic [7:0] occurrence;
  } cfg_t;

  typedef struct packed {
    logic pipe_valid;
    logic scan_done;
  } scan_status_t;

endpackage

@@ design/pnprts_if.sv @@
// ----------------------------------------------------------------------------
// pnprts_if: stream channels of the PnP resource tag scanner
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pnprts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;

  modport source(output valid, output data_byte, output stream_start, input ready);
  modport sink(input valid, input data_byte, input stream_start, output ready);
endinterface

interface pnprts_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] packet_offset;

  modport source(output valid, output found, output packet_offset, input ready);
  modport sink(input valid, input found, input packet_offset, output ready);
endinterface

@@ design/pnprts_cfg.sv @@
// ----------------------------------------------------------------------------
// pnprts_cfg: configuration registers
// APB-style register file holding the search setup.
// ----------------------------------------------------------------------------
module pnprts_cfg
  import pnprts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_SEARCH_MODE: cfg.search_mode <= pwdata[1:0];
        REG_WANTED_TAG:  cfg.wanted_tag  <= pwdata[7:0];
        REG_WANTED_TYPE: cfg.wanted_type <= pwdata[7:0];
        REG_OCCURRENCE:  cfg.occurrence  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SEARCH_MODE: prdata = {{(APB_DATA_W-2){1'b0}}, cfg.search_mode};
      REG_WANTED_TAG:  prdata = {{(APB_DATA_W-8){1'b0}}, cfg.wanted_tag};
      REG_WANTED_TYPE: prdata = {{(APB_DATA_W-8){1'b0}}, cfg.wanted_type};
      REG_OCCURRENCE:  prdata = {{(APB_DATA_W-8){1'b0}}, cfg.occurrence};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ design/pnprts_core.sv @@
// ----------------------------------------------------------------------------
// pnprts_core: byte scanner
// Input register, one-pass packet boundary and match logic, result register.
// ----------------------------------------------------------------------------
module pnprts_core
  import pnprts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
)(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_byte,
  input  logic                    in_start,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_found,
  output logic [RESULT_OFF_W-1:0] out_offset,
  output scan_status_t            status
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY
  } phase_t;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  // Input register
  logic                   pipe_valid;
  logic [7:0]             pipe_byte;
  logic                   pipe_start;

  // Scan state
  phase_t                 phase;
  logic [15:0]            bytes_left;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [OFFSET_BITS-1:0] cand_start;
  logic [7:0]             matches_seen;
  logic                   type_pending;
  logic [1:0]             type_wait;
  logic                   scan_done;

  // State as seen by the current byte, after a stream start clears it
  phase_t                 e_phase;
  logic [15:0]            e_left;
  logic [OFFSET_BITS-1:0] e_off;
  logic [OFFSET_BITS-1:0] e_cand;
  logic [7:0]             e_matches;
  logic                   e_pending;
  logic [1:0]             e_wait;
  logic                   e_done;

  phase_t                 phase_next;
  logic [15:0]            bytes_left_next;
  logic [OFFSET_BITS-1:0] byte_offset_next;
  logic [OFFSET_BITS-1:0] cand_start_next;
  logic [7:0]             matches_seen_next;
  logic                   type_pending_next;
  logic [1:0]             type_wait_next;
  logic                   scan_done_next;

  logic [1:0]             wait_dec;
  logic                   type_fire;
  logic                   type_hit;
  logic                   type_win;
  logic [7:0]             matches_mid;
  logic                   is_header;
  logic                   end_hit;
  logic                   generic_mode;
  logic [7:0]             tag_mask;
  logic                   gen_hit;
  logic                   gen_win;
  logic [15:0]            left_dec;
  logic [15:0]            len_full;
  logic                   emit;
  logic                   emit_found;
  logic [OFFSET_BITS-1:0] emit_off;
  logic [OFFSET_BITS+RESULT_OFF_W-1:0] emit_off_ext;
  logic                   advance;

  always_comb begin
    e_phase   = pipe_start ? PH_HEADER : phase;
    e_left    = pipe_start ? '0 : bytes_left;
    e_off     = pipe_start ? '0 : byte_offset;
    e_cand    = pipe_start ? '0 : cand_start;
    e_matches = pipe_start ? '0 : matches_seen;
    e_pending = pipe_start ? 1'b0 : type_pending;
    e_wait    = pipe_start ? '0 : type_wait;
    e_done    = pipe_start ? 1'b0 : scan_done;

    // A pending vendor type compare runs before this byte's own parsing.
    wait_dec    = (e_wait != '0) ? e_wait - 2'd1 : '0;
    type_fire   = e_pending && (wait_dec == '0);
    type_hit    = type_fire && (pipe_byte == cfg.wanted_type);
    type_win    = type_hit && (e_matches == cfg.occurrence);
    matches_mid = (type_hit && !type_win) ? e_matches + 8'd1 : e_matches;

    is_header    = (e_phase == PH_HEADER);
    end_hit      = is_header && (pipe_byte == END_TAG);
    generic_mode = (cfg.search_mode != MODE_SMALL_VENDOR) &&
                   (cfg.search_mode != MODE_LARGE_VENDOR);
    tag_mask     = cfg.wanted_tag[7] ? FULL_MASK : TAG_MASK;
    gen_hit      = is_header && !end_hit && generic_mode &&
                   ((pipe_byte & tag_mask) == (cfg.wanted_tag & tag_mask));
    gen_win      = gen_hit && (matches_mid == cfg.occurrence);

    emit       = !e_done && (type_win || end_hit || gen_win);
    emit_found = type_win || !end_hit;
    if (type_win) begin
      emit_off = e_cand;
    end else if (end_hit) begin
      emit_off = '0;
    end else begin
      emit_off = e_off;
    end
    emit_off_ext = {{RESULT_OFF_W{1'b0}}, emit_off};

    left_dec = (e_left != '0) ? e_left - 16'd1 : '0;
    len_full = {pipe_byte, e_left[7:0]};

    phase_next        = e_phase;
    bytes_left_next   = e_left;
    byte_offset_next  = (e_off == OFF_MAX) ? e_off : e_off + 1'b1;
    cand_start_next   = e_cand;
    matches_seen_next = (gen_hit && !gen_win) ? matches_mid + 8'd1 : matches_mid;
    type_pending_next = e_pending && !type_fire;
    type_wait_next    = e_pending ? wait_dec : e_wait;
    scan_done_next    = emit;

    if (is_header) begin
      if ((cfg.search_mode == MODE_SMALL_VENDOR) &&
          ((pipe_byte & TAG_MASK) == SMALL_VENDOR)) begin
        type_pending_next = 1'b1;
        type_wait_next    = SMALL_TYPE_DIST;
        cand_start_next   = e_off;
      end else if ((cfg.search_mode == MODE_LARGE_VENDOR) &&
                   (pipe_byte == LARGE_VENDOR)) begin
        type_pending_next = 1'b1;
        type_wait_next    = LARGE_TYPE_DIST;
        cand_start_next   = e_off;
      end
    end

    case (e_phase)
      PH_HEADER: begin
        if (pipe_byte[7]) begin
          phase_next = PH_LEN_LO;
        end else begin
          bytes_left_next = {13'd0, pipe_byte[2:0]};
          phase_next      = (pipe_byte[2:0] != 3'd0) ? PH_BODY : PH_HEADER;
        end
      end
      PH_LEN_LO: begin
        bytes_left_next = {8'd0, pipe_byte};
        phase_next      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        bytes_left_next = len_full;
        phase_next      = (len_full != '0) ? PH_BODY : PH_HEADER;
      end
      default: begin
        bytes_left_next = left_dec;
        phase_next      = (left_dec == '0) ? PH_HEADER : PH_BODY;
      end
    endcase

    // An idle scanner drops bytes and keeps its state.
    if (e_done) begin
      phase_next        = phase;
      bytes_left_next   = bytes_left;
      byte_offset_next  = byte_offset;
      cand_start_next   = cand_start;
      matches_seen_next = matches_seen;
      type_pending_next = type_pending;
      type_wait_next    = type_wait;
      scan_done_next    = 1'b1;
    end
  end

  // The byte in the input register moves on unless it carries a result
  // and the result register is occupied and not being read.
  assign advance  = pipe_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !pipe_valid || advance;
  assign status   = '{pipe_valid: pipe_valid, scan_done: scan_done};

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid   <= 1'b0;
      out_valid    <= 1'b0;
      phase        <= PH_HEADER;
      bytes_left   <= '0;
      byte_offset  <= '0;
      cand_start   <= '0;
      matches_seen <= '0;
      type_pending <= 1'b0;
      type_wait    <= '0;
      scan_done    <= 1'b1;
    end else begin
      if (in_valid && in_ready) begin
        pipe_valid <= 1'b1;
        pipe_byte  <= in_byte;
        pipe_start <= in_start;
      end else if (advance) begin
        pipe_valid <= 1'b0;
      end

      if (advance) begin
        phase        <= phase_next;
        bytes_left   <= bytes_left_next;
        byte_offset  <= byte_offset_next;
        cand_start   <= cand_start_next;
        matches_seen <= matches_seen_next;
        type_pending <= type_pending_next;
        type_wait    <= type_wait_next;
        scan_done    <= scan_done_next;
      end

      if (advance && emit) begin
        out_valid  <= 1'b1;
        out_found  <= emit_found;
        out_offset <= emit_off_ext[RESULT_OFF_W-1:0];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/pnp_resource_tag_scanner_top.sv @@
// ----------------------------------------------------------------------------
// pnp_resource_tag_scanner_top: PnP resource tag stream scanner
// Follows packet boundaries in a resource byte stream and reports the offset
// of the requested packet, or not-found at the end tag.
// ----------------------------------------------------------------------------
// The scanner takes one stream byte per clock with no gaps of its own. A byte
// is captured in an input register and parsed in a single pass from there
// into the result register, where its result waits until it is taken. The
// input side stalls only when a byte produces a result while the previous
// result still sits unread in the result register. Each stream yields at most
// one result beat; bytes that arrive after it are dropped until a beat with
// stream_start set. The user must write registers over the APB port only
// while no byte is in flight; the block itself does not enforce it.
module pnp_resource_tag_scanner_top
  import pnprts_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
)(
  input  logic                  clk,
  input  logic                  rst,
  pnprts_in_if.sink             byte_in,
  pnprts_out_if.source          result_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t         cfg;
  scan_status_t status;

  pnprts_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pnprts_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (byte_in.valid),
    .in_ready   (byte_in.ready),
    .in_byte    (byte_in.data_byte),
    .in_start   (byte_in.stream_start),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_found  (result_out.found),
    .out_offset (result_out.packet_offset),
    .status     (status)
  );

`ifndef ASSERT_OFF
  // A new result always comes from a byte that sat in the input register.
  a_result_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(result_out.valid) |-> $past(status.pipe_valid))
    else $error("result appeared without a byte in the input register");

  // Delivering a result ends the scan of that stream.
  a_result_ends_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(result_out.valid) |-> status.scan_done)
    else $error("scan still running after its result");

  // A not-found result carries a zero offset.
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.found) |-> (result_out.packet_offset == '0))
    else $error("not-found result with nonzero offset");
`endif

endmodule
